// ----- rtl/core/rmsn_pkg.sv -----
package rmsn_pkg;

   // default vector length limit and input queue depth
   localparam int MaxDimDefault = 4096;
   localparam int QueueDepth    = 4;

   // fixed field widths
   localparam int DataW  = 16;
   localparam int EpsW   = 24;
   localparam int SumW   = 44;
   localparam int ScaleW = 32;

   // reset value of epsilon
   localparam logic [EpsW-1:0] EpsReset = 24'd17;

   // modes of an input item
   localparam logic ModeAccumulate = 1'b0;
   localparam logic ModeNormalize  = 1'b1;

   // one input item as it travels from front to back
   typedef struct packed {
      logic                    mode;
      logic signed [DataW-1:0] element;
      logic signed [DataW-1:0] gain;
      logic                    final_item;
   } item_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// ----- rtl/core/rmsn_front.sv -----
module rmsn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  rmsn_pkg::item_type in_item,
   output rmsn_pkg::head_type head,
   input  logic              head_pop
);
   import rmsn_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   item_type            slot_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     fill_ff, fill_in;
   logic                do_push, do_pop;

   // handshake qualification
   assign full    = (fill_ff == CntW'(QueueDepth));
   assign do_push = push && !full;
   assign do_pop  = head_pop && (fill_ff != '0);

   // head of queue
   assign head.valid = (fill_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- rtl/core/rmsn_back.sv -----
module rmsn_back #(
   parameter int MAX_DIM = rmsn_pkg::MaxDimDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rmsn_pkg::head_type                  head,
   output logic                                head_pop,
   input  logic [rmsn_pkg::EpsW-1:0]           epsilon,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [rmsn_pkg::DataW-1:0]   normalized,
   output logic                                clipped,
   output logic                                end_of_vector
);
   import rmsn_pkg::*;

   localparam int CntW  = $clog2(MAX_DIM + 1);
   localparam int NumW  = 65;
   localparam int DenW  = 45;
   localparam int StepW = 7;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MEAN  = 6'b000010,
      ST_SCALE = 6'b000100,
      ST_ROOT  = 6'b001000,
      ST_PROD  = 6'b010000,
      ST_ROUND = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [SumW-1:0]      sum_ff, sum_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [ScaleW-1:0]    inv_ff, inv_in;
   logic [NumW-1:0]      num_ff, num_in;
   logic [DenW-1:0]      den_ff, den_in;
   logic [DenW-1:0]      rem_ff, rem_in;
   logic [NumW-1:0]      quo_ff, quo_in;
   logic [StepW-1:0]     step_ff, step_in;
   logic [63:0]          root_n_ff, root_n_in;
   logic [63:0]          root_r_ff, root_r_in;
   logic [63:0]          root_b_ff, root_b_in;
   logic [30:0]          p1_ff, p1_in;
   logic [62:0]          p2_ff, p2_in;
   logic                 neg_ff, neg_in;
   logic                 fin_ff, fin_in;
   logic                 out_valid_ff, out_valid_in;
   logic [DataW-1:0]     out_data_ff, out_data_in;
   logic                 out_clip_ff, out_clip_in;
   logic                 out_eov_ff, out_eov_in;

   logic [DataW-1:0]     ax, ag;
   logic [31:0]          sq;
   logic [SumW:0]        sum_add;
   logic                 room;
   logic [SumW-1:0]      acc_sum;
   logic [CntW-1:0]      acc_cnt;
   logic [DenW:0]        rem_shift;
   logic                 quo_bit;
   logic [DenW-1:0]      rem_step;
   logic [NumW-1:0]      quo_step;
   logic [SumW-1:0]      mean;
   logic [DenW-1:0]      vsum;
   logic [63:0]          root_t;
   logic [63:0]          rnd_sum;
   logic [31:0]          rnd_mag;
   logic                 out_free;

   // magnitudes of the head item's fields
   assign ax = head.item.element[DataW-1] ? (~head.item.element + 1'b1) : head.item.element;
   assign ag = head.item.gain[DataW-1] ? (~head.item.gain + 1'b1) : head.item.gain;

   // accumulate one square, saturating sum, count stops at the limit
   assign sq      = ax * ax;
   assign sum_add = {1'b0, sum_ff} + {13'b0, sq};
   assign room    = (count_ff < CntW'(MAX_DIM));
   assign acc_sum = room ? (sum_add[SumW] ? '1 : sum_add[SumW-1:0]) : sum_ff;
   assign acc_cnt = room ? count_ff + 1'b1 : count_ff;

   // one restoring division step
   assign rem_shift = {rem_ff, num_ff[NumW-1]};
   assign quo_bit   = (rem_shift >= {1'b0, den_ff});
   assign rem_step  = quo_bit ? DenW'(rem_shift - {1'b0, den_ff}) : rem_shift[DenW-1:0];
   assign quo_step  = {quo_ff[NumW-2:0], quo_bit};

   // mean square plus epsilon, zero mean for an empty vector
   assign mean = (den_ff == '0) ? '0 : quo_step[SumW-1:0];
   assign vsum = {1'b0, mean} + {21'b0, epsilon};

   // one square root step
   assign root_t = root_r_ff + root_b_ff;

   // round half away from zero, dropping the 32 fraction bits of the Q0.32 scale
   assign rnd_sum = {1'b0, p2_ff} + 64'h0000_0000_8000_0000;
   assign rnd_mag = rnd_sum[63:32];

   assign out_free = !out_valid_ff || pop;
   assign head_pop = (state_ff == ST_IDLE) && head.valid;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      inv_in       = inv_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      root_n_in    = root_n_ff;
      root_r_in    = root_r_ff;
      root_b_in    = root_b_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      neg_in       = neg_ff;
      fin_in       = fin_ff;
      out_valid_in = out_valid_ff && !pop;
      out_data_in  = out_data_ff;
      out_clip_in  = out_clip_ff;
      out_eov_in   = out_eov_ff;
      case (state_ff)
         // take the next item from the queue
         ST_IDLE: begin
            if (head.valid) begin
               if (head.item.mode == ModeAccumulate) begin
                  sum_in   = acc_sum;
                  count_in = acc_cnt;
                  if (head.item.final_item) begin
                     num_in   = {21'b0, acc_sum};
                     den_in   = {{(DenW-CntW){1'b0}}, acc_cnt};
                     rem_in   = '0;
                     quo_in   = '0;
                     step_in  = StepW'(NumW - 1);
                     sum_in   = '0;
                     count_in = '0;
                     state_in = ST_MEAN;
                  end
               end else begin
                  p1_in    = ax * ag;
                  neg_in   = head.item.element[DataW-1] ^ head.item.gain[DataW-1];
                  fin_in   = head.item.final_item;
                  state_in = ST_PROD;
               end
            end
         end
         // sum over count
         ST_MEAN: begin
            num_in = {num_ff[NumW-2:0], 1'b0};
            rem_in = rem_step;
            quo_in = quo_step;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               if (vsum[DenW-1:1] == '0) begin
                  inv_in   = '1;
                  state_in = ST_IDLE;
               end else begin
                  num_in   = {1'b1, 64'b0};
                  den_in   = vsum;
                  rem_in   = '0;
                  quo_in   = '0;
                  step_in  = StepW'(NumW - 1);
                  state_in = ST_SCALE;
               end
            end
         end
         // two to the 64 over the mean square plus epsilon
         ST_SCALE: begin
            num_in = {num_ff[NumW-2:0], 1'b0};
            rem_in = rem_step;
            quo_in = quo_step;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               root_n_in = quo_step[63:0];
               root_r_in = '0;
               root_b_in = 64'h4000_0000_0000_0000;
               step_in   = StepW'(31);
               state_in  = ST_ROOT;
            end
         end
         // bitwise integer square root, two bits a step
         ST_ROOT: begin
            if (root_n_ff >= root_t) begin
               root_n_in = root_n_ff - root_t;
               root_r_in = (root_r_ff >> 1) + root_b_ff;
            end else begin
               root_r_in = root_r_ff >> 1;
            end
            root_b_in = root_b_ff >> 2;
            step_in   = step_ff - 1'b1;
            if (step_ff == '0) begin
               inv_in   = root_r_in[ScaleW-1:0];
               state_in = ST_IDLE;
            end
         end
         // product with the scale
         ST_PROD: begin
            p2_in    = p1_ff * inv_ff;
            state_in = ST_ROUND;
         end
         // round, saturate and hand to the result register once it is free
         ST_ROUND: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_eov_in   = fin_ff;
               if (!neg_ff) begin
                  out_clip_in = (rnd_mag > 32'd32767);
                  out_data_in = out_clip_in ? 16'h7FFF : rnd_mag[DataW-1:0];
               end else begin
                  out_clip_in = (rnd_mag > 32'd32768);
                  out_data_in = out_clip_in ? 16'h8000 : DataW'(~rnd_mag[DataW-1:0] + 1'b1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and vector state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         inv_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         inv_ff       <= inv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      root_n_ff   <= root_n_in;
      root_r_ff   <= root_r_in;
      root_b_ff   <= root_b_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      neg_ff      <= neg_in;
      fin_ff      <= fin_in;
      out_data_ff <= out_data_in;
      out_clip_ff <= out_clip_in;
      out_eov_ff  <= out_eov_in;
   end

   // result port
   assign empty         = !out_valid_ff;
   assign normalized    = out_data_ff;
   assign clipped       = out_clip_ff;
   assign end_of_vector = out_eov_ff;

endmodule

// ----- rtl/core/rms_normalizer_top.sv -----
// accumulate items add to the registered sum; normalize items go from the queue through the
// magnitude product, scale product and rounding registers; the engine takes one accumulate
// item per cycle while idle and finishes each normalize item before taking the next; a final
// accumulate adds two 65-step divisions and a 32-step root, one division if saturated
// reset: synchronous; clears queue, sums, count, scale to zero and epsilon to 17
module rms_normalizer_top #(
   parameter int MAX_DIM = rmsn_pkg::MaxDimDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_mode,
   input  logic signed [rmsn_pkg::DataW-1:0] req_element,
   input  logic signed [rmsn_pkg::DataW-1:0] req_gain,
   input  logic                              req_final_item,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [rmsn_pkg::DataW-1:0] rsp_normalized,
   output logic                              rsp_clipped,
   output logic                              rsp_end_of_vector,
   input  logic                              csr_wr_en,
   input  logic [rmsn_pkg::EpsW-1:0]         csr_wr_data
);
   import rmsn_pkg::*;

   item_type        in_item;
   head_type        head;
   logic            head_pop;
   logic [EpsW-1:0] eps_ff;

   // epsilon register
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EpsReset;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   assign in_item.mode       = req_mode;
   assign in_item.element    = req_element;
   assign in_item.gain       = req_gain;
   assign in_item.final_item = req_final_item;

   // input queue
   rmsn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .in_item  (in_item),
      .head     (head),
      .head_pop (head_pop)
   );

   // accumulate, scale and normalize engine
   rmsn_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_pop      (head_pop),
      .epsilon       (eps_ff),
      .empty         (empty),
      .pop           (pop),
      .normalized    (rsp_normalized),
      .clipped       (rsp_clipped),
      .end_of_vector (rsp_end_of_vector)
   );

endmodule

// ----- test/rms_normalizer_checker.sv -----
`timescale 1ns / 1ps

module rms_normalizer_checker #(
   parameter int MAX_DIM = rmsn_pkg::MaxDimDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic                              full,
   input  logic                              req_mode,
   input  logic signed [rmsn_pkg::DataW-1:0] req_element,
   input  logic signed [rmsn_pkg::DataW-1:0] req_gain,
   input  logic                              req_final_item,
   input  logic                              empty,
   input  logic                              pop,
   input  logic signed [rmsn_pkg::DataW-1:0] rsp_normalized,
   input  logic                              rsp_clipped,
   input  logic                              rsp_end_of_vector,
   input  logic                              csr_wr_en,
   input  logic [rmsn_pkg::EpsW-1:0]         csr_wr_data,
   output int                                failures,
   output int                                pending,
   output int                                checked
);

   import rmsn_pkg::*;

   localparam logic [63:0] SquareSumMax = (64'd1 << SumW) - 64'd1;

   // one expected result
   typedef struct packed {
      logic signed [DataW-1:0] normalized;
      logic                    clipped;
      logic                    end_of_vector;
   } norm_result_type;

   norm_result_type expected_norms[$];

   // predicted block state
   logic [EpsW-1:0]   epsilon;
   logic [63:0]       square_sum;
   int unsigned       element_count;
   logic [ScaleW-1:0] inverse_rms;

   // integer square root, one result bit per step
   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] probe;
      res   = '0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= res + probe) begin
            n   = n - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // floor(sqrt(2^64 / v)) as unsigned Q0.32, saturated
   function automatic logic [ScaleW-1:0] rsqrt_scale(logic [63:0] v);
      logic [64:0] quotient;
      logic [63:0] root;
      if (v <= 64'd1) return '1;
      quotient = {1'b1, 64'd0} / {1'b0, v};
      root = int_sqrt(quotient[63:0]);
      if (root > 64'hFFFF_FFFF) return '1;
      return root[ScaleW-1:0];
   endfunction

   // element * gain * scale, rounded half away from zero and saturated
   function automatic norm_result_type scale_element(logic signed [DataW-1:0] x,
                                                     logic signed [DataW-1:0] g,
                                                     logic fin);
      norm_result_type res;
      longint          xi;
      longint          gi;
      logic [63:0]     mag;
      logic [63:0]     rounded;
      logic            neg;
      xi = x;
      gi = g;
      neg = (xi < 0) != (gi < 0);
      if (xi < 0) xi = -xi;
      if (gi < 0) gi = -gi;
      mag = 64'(xi) * 64'(gi) * 64'(inverse_rms);
      rounded = (mag + (64'd1 << 31)) >> 32;
      res.clipped = 1'b0;
      res.end_of_vector = fin;
      if (!neg) begin
         if (rounded > 64'd32767) begin
            rounded = 64'd32767;
            res.clipped = 1'b1;
         end
         res.normalized = rounded[DataW-1:0];
      end else begin
         if (rounded > 64'd32768) begin
            rounded = 64'd32768;
            res.clipped = 1'b1;
         end
         res.normalized = -rounded[DataW-1:0];
      end
      return res;
   endfunction

   assign pending = expected_norms.size();

   // predict on accepted items, compare accepted results
   always @(posedge clock) begin
      norm_result_type want;
      longint          xi;
      logic [63:0]     sq;
      logic [63:0]     mean;
      if (reset) begin
         epsilon       = EpsReset;
         square_sum    = '0;
         element_count = 0;
         inverse_rms   = '0;
         expected_norms.delete();
         failures      = 0;
         checked       = 0;
      end else begin
         // register write
         if (csr_wr_en) epsilon = csr_wr_data;

         // accepted input item
         if (push && !full) begin
            if (req_mode == ModeAccumulate) begin
               if (element_count < MAX_DIM) begin
                  xi = req_element;
                  sq = 64'(xi * xi);
                  square_sum = (square_sum > SquareSumMax - sq) ? SquareSumMax
                                                                 : square_sum + sq;
                  element_count++;
               end
               if (req_final_item) begin
                  mean = (element_count != 0) ? square_sum / element_count : 64'd0;
                  inverse_rms   = rsqrt_scale(mean + 64'(epsilon));
                  square_sum    = '0;
                  element_count = 0;
               end
            end else begin
               expected_norms.push_back(scale_element(req_element, req_gain,
                                                      req_final_item));
            end
         end

         // accepted result item
         if (pop && !empty) begin
            if (expected_norms.size() == 0) begin
               $error("result item with nothing expected: normalized %0d",
                      rsp_normalized);
               failures++;
            end else begin
               want = expected_norms.pop_front();
               checked++;
               if (rsp_normalized !== want.normalized) begin
                  $error("normalized: expected %0d, actual %0d",
                         want.normalized, rsp_normalized);
                  failures++;
               end
               if (rsp_clipped !== want.clipped) begin
                  $error("clipped: expected %0d, actual %0d", want.clipped, rsp_clipped);
                  failures++;
               end
               if (rsp_end_of_vector !== want.end_of_vector) begin
                  $error("end_of_vector: expected %0d, actual %0d",
                         want.end_of_vector, rsp_end_of_vector);
                  failures++;
               end
            end
         end
      end
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   import rmsn_pkg::*;

   localparam int RandomItems = 1950;
   localparam int SettleCycles = 1000;
   localparam longint CycleLimit = 3_000_000;

   logic                    clock;
   logic                    reset;
   logic                    push;
   logic                    full;
   logic                    req_mode;
   logic signed [DataW-1:0] req_element;
   logic signed [DataW-1:0] req_gain;
   logic                    req_final_item;
   logic                    empty;
   logic                    pop;
   logic signed [DataW-1:0] rsp_normalized;
   logic                    rsp_clipped;
   logic                    rsp_end_of_vector;
   logic                    csr_wr_en;
   logic [EpsW-1:0]         csr_wr_data;

   int     failures;
   int     pending;
   int     checked;
   int     items_sent;
   int     vectors_sent;
   bit     no_gaps;
   longint cycle_count;

   rms_normalizer_top DUT (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_mode(req_mode), .req_element(req_element), .req_gain(req_gain),
      .req_final_item(req_final_item), .empty(empty), .pop(pop),
      .rsp_normalized(rsp_normalized), .rsp_clipped(rsp_clipped),
      .rsp_end_of_vector(rsp_end_of_vector), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   rms_normalizer_checker CHECKER (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_mode(req_mode), .req_element(req_element), .req_gain(req_gain),
      .req_final_item(req_final_item), .empty(empty), .pop(pop),
      .rsp_normalized(rsp_normalized), .rsp_clipped(rsp_clipped),
      .rsp_end_of_vector(rsp_end_of_vector), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data), .failures(failures), .pending(pending),
      .checked(checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // gap before the next item on either side
   function automatic int draw_gap();
      if (no_gaps) return 0;
      return $urandom_range(0, 12);
   endfunction

   // result side: random pop stalls
   initial begin
      int gap;
      pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop = 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   // present one item and hold it until accepted
   task automatic send_item(logic mode, logic signed [DataW-1:0] element,
                            logic signed [DataW-1:0] gain, logic fin, bit gaps_on);
      int gap;
      @(negedge clock);
      gap = gaps_on ? draw_gap() : 0;
      if (gap > 0) begin
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      push           = 1'b1;
      req_mode       = mode;
      req_element    = element;
      req_gain       = gain;
      req_final_item = fin;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   // drain results, let a final accumulate finish, then write epsilon
   task automatic set_epsilon(logic [EpsW-1:0] value);
      @(negedge clock);
      push = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // one vector: accumulate pass, then normalize pass, random content
   task automatic send_vector();
      int   len;
      int   norm_len;
      int   span;
      logic signed [DataW-1:0] el;
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150)
                                             : $urandom_range(1, 24);
      norm_len = $urandom_range(1, 24);
      // magnitude range picks how large the scale gets
      case ($urandom_range(0, 3))
         0: span = 32767;
         1: span = 4095;
         2: span = 255;
         default: span = 15;
      endcase
      for (int i = 0; i < len; i++) begin
         el = (span == 32767) ? DataW'($urandom) : DataW'($urandom_range(0, 2 * span) - span);
         send_item(ModeAccumulate, el, DataW'($urandom), i == len - 1, 1'b1);
      end
      for (int i = 0; i < norm_len; i++) begin
         send_item(ModeNormalize, DataW'($urandom), DataW'($urandom), i == norm_len - 1, 1'b1);
      end
      vectors_sent++;
   endtask

   // stimulus and verdict
   initial begin
      logic [EpsW-1:0] eps_values[4];
      push           = 1'b0;
      req_mode       = ModeAccumulate;
      req_element    = '0;
      req_gain       = '0;
      req_final_item = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      items_sent     = 0;
      vectors_sent   = 0;
      no_gaps        = 1'b0;
      reset          = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // normalize before any scale exists gives zero
      send_item(ModeNormalize, -16'sd32768, -16'sd32768, 1'b0, 1'b1);
      send_item(ModeNormalize, 16'sd32767, 16'sd32767, 1'b1, 1'b1);
      // largest square, then extreme products with the reset epsilon
      send_item(ModeAccumulate, -16'sd32768, 16'sd0, 1'b1, 1'b1);
      send_item(ModeNormalize, -16'sd32768, 16'sd32767, 1'b0, 1'b1);
      send_item(ModeNormalize, 16'sd32767, 16'sd32767, 1'b0, 1'b1);
      send_item(ModeNormalize, -16'sd32768, -16'sd32768, 1'b0, 1'b1);
      send_item(ModeNormalize, 16'sd1, 16'sd1, 1'b0, 1'b1);
      send_item(ModeNormalize, 16'sd0, 16'sd5, 1'b1, 1'b1);
      // zero vector: scale set by epsilon alone
      send_item(ModeAccumulate, 16'sd0, 16'sd0, 1'b1, 1'b1);
      send_item(ModeNormalize, 16'sd32767, 16'sd32767, 1'b1, 1'b1);
      send_item(ModeNormalize, 16'sd1, -16'sd1, 1'b1, 1'b1);

      // zero epsilon: mean square of zero and of one saturate the scale
      set_epsilon('0);
      send_item(ModeAccumulate, 16'sd0, 16'sd0, 1'b1, 1'b1);
      send_item(ModeNormalize, 16'sd1, 16'sd1, 1'b0, 1'b1);
      send_item(ModeNormalize, -16'sd1, 16'sd1, 1'b1, 1'b1);
      send_item(ModeAccumulate, 16'sd1, 16'sd0, 1'b0, 1'b1);
      send_item(ModeAccumulate, -16'sd1, 16'sd0, 1'b1, 1'b1);
      send_item(ModeNormalize, 16'sd2, 16'sd4096, 1'b1, 1'b1);

      // random part over several epsilon settings, extremes included
      eps_values[0] = EpsReset;
      eps_values[1] = '1;
      eps_values[2] = EpsW'($urandom);
      eps_values[3] = EpsW'($urandom_range(0, 255));
      items_sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         set_epsilon(eps_values[phase]);
         while (items_sent < (phase + 1) * RandomItems / 4) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
               // noise: unstructured items
               repeat ($urandom_range(1, 6))
                  send_item(1'($urandom), DataW'($urandom), DataW'($urandom),
                            1'($urandom), 1'b1);
            end else begin
               send_vector();
            end
         end
         no_gaps = 1'b0;
      end

      @(negedge clock);
      push = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);

      $display("covered %0d random items in %0d vectors, %0d results checked",
               items_sent, vectors_sent, checked);
      $display("epsilon settings: reset, zero, all ones and random; %0d cycles",
               cycle_count);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
